FILE: rtl/core/omw_pkg.sv
// ----------------------------------------------------------------------------
// omw_pkg
// Shared types and constants of the three-wheel omni drive mixer: field
// widths, register reset values, register indexes, fixed-point constants and
// the command word that the controller sends to the datapath.
// ----------------------------------------------------------------------------
package omw_pkg;

  localparam int DUTY_BITS   = 16;
  localparam int DUTY_PORT_W = 16;
  localparam int BYTE_W      = 8;
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_IDX_W   = 3;
  localparam int GAIN_W      = 12;
  localparam int PULSE_W     = 12;
  localparam int LIMIT_W     = 16;
  localparam int NUM_WHEELS  = 3;
  localparam int SEL_W       = 2;

  localparam logic [SEL_W-1:0] POS_LAST   = SEL_W'(3);
  localparam logic [SEL_W-1:0] WHEEL_LAST = SEL_W'(NUM_WHEELS - 1);

  localparam logic [BYTE_W-1:0]  CENTER_RST  = BYTE_W'(127);
  localparam logic [GAIN_W-1:0]  GAIN_RST    = GAIN_W'(640);
  localparam logic [LIMIT_W-1:0] LIMIT_RST   = LIMIT_W'(64881);
  localparam logic [BYTE_W-1:0]  ARM_CODE_RST = BYTE_W'(8'h23);
  localparam logic [PULSE_W-1:0] ARM_ON_RST  = PULSE_W'(1190);
  localparam logic [PULSE_W-1:0] ARM_OFF_RST = PULSE_W'(1700);
  localparam logic [PULSE_W-1:0] PULSE_RST   = PULSE_W'(1700);

  // Signed counts and the wheel speed accumulator in units of 2^-16 count.
  localparam int DIFF_W   = BYTE_W + 1;
  localparam int TURN_W   = GAIN_W + DIFF_W;
  localparam int YK_W     = 26;
  localparam int ACC_W    = 32;
  localparam int MAG_W    = 30;
  localparam int SQRT3_HALF_Q16 = 56756;
  localparam int X_SHIFT  = 16;
  localparam int XH_SHIFT = 15;
  localparam int T_SHIFT  = 8;

  // Duty = round(mag * 2^DUTY_BITS / (127 * 2^16)), done as a scaled
  // rounding shift followed by a reciprocal multiply for the divide by 127.
  localparam int FULL_SCALE  = 127;
  localparam int ROUND_W     = MAG_W + DUTY_BITS + 1;
  localparam longint RND_OFS = longint'(FULL_SCALE) * (longint'(1) << 15);
  localparam int SCAP_W      = DUTY_BITS + 7;
  localparam longint SCAP    = longint'(FULL_SCALE) * (longint'(1) << DUTY_BITS) - 1;
  localparam int RECIP_SHIFT = 30;
  localparam int RECIP_W     = 24;
  localparam longint RECIP   = ((longint'(1) << RECIP_SHIFT) + FULL_SCALE - 1) / FULL_SCALE;
  localparam int PROD_W      = SCAP_W + RECIP_W;
  localparam logic [LIMIT_W-1:0] DUTY_TOP = LIMIT_W'((longint'(1) << DUTY_BITS) - 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CENTER  = 3'd0,
    CFG_GAIN    = 3'd1,
    CFG_LIMIT   = 3'd2,
    CFG_ARMCODE = 3'd3,
    CFG_ARM_ON  = 3'd4,
    CFG_ARM_OFF = 3'd5
  } cfg_idx_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_STORE,
    OP_FRAME,
    OP_MUL,
    OP_ACC,
    OP_ROUND,
    OP_DIV,
    OP_CLAMP,
    OP_PUBLISH
  } op_e;

  typedef struct packed {
    op_e              op;
    logic [SEL_W-1:0] sel;
  } omw_cmd_t;

endpackage

FILE: rtl/core/omw_datapath.sv
// ----------------------------------------------------------------------------
// omw_datapath
// Frame store, configuration registers, arm state, the shared wheel speed
// unit and the result register of the omni drive mixer.
// ----------------------------------------------------------------------------
module omw_datapath (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  omw_pkg::omw_cmd_t                 cmd_i,
  input  logic [omw_pkg::BYTE_W-1:0]        rx_byte_i,
  input  logic                              cfg_we_i,
  input  logic [omw_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [omw_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  output logic [omw_pkg::DUTY_PORT_W-1:0]   wheel1_fwd_o,
  output logic [omw_pkg::DUTY_PORT_W-1:0]   wheel1_rev_o,
  output logic [omw_pkg::DUTY_PORT_W-1:0]   wheel2_fwd_o,
  output logic [omw_pkg::DUTY_PORT_W-1:0]   wheel2_rev_o,
  output logic [omw_pkg::DUTY_PORT_W-1:0]   wheel3_fwd_o,
  output logic [omw_pkg::DUTY_PORT_W-1:0]   wheel3_rev_o,
  output logic [omw_pkg::PULSE_W-1:0]       arm_pulse_us_o
);
  import omw_pkg::*;

  logic [BYTE_W-1:0]  center_q;
  logic [GAIN_W-1:0]  gain_q;
  logic [LIMIT_W-1:0] limit_q;
  logic [BYTE_W-1:0]  arm_code_q;
  logic [PULSE_W-1:0] arm_on_q;
  logic [PULSE_W-1:0] arm_off_q;
  logic [BYTE_W-1:0]  prev_code_q;
  logic [PULSE_W-1:0] arm_pulse_q;

  logic [BYTE_W-1:0] store_q [NUM_WHEELS];

  logic signed [DIFF_W-1:0] xd_q, yd_q, rd_q;
  logic signed [DIFF_W-1:0] xd_d, yd_d, rd_d;
  logic signed [TURN_W-1:0] t_q, t_d, gain_ext, rd_ext;
  logic signed [YK_W-1:0]   yk_q, yk_d, yd_ext, sqrt_ext;

  logic signed [ACC_W-1:0] x_ext, yk_ext, t_ext, acc;
  logic [ACC_W-1:0]        acc_abs;
  logic [MAG_W-1:0]        mag_q;
  logic                    sgn_pos_q, sgn_neg_q;

  logic [ROUND_W-1:0]   rnd_sum, rnd_shift;
  logic [SCAP_W-1:0]    scap_q, scap_d;
  logic [PROD_W-1:0]    prod;
  logic [DUTY_BITS-1:0] quo_q;
  logic [DUTY_BITS-1:0] lim, duty;

  logic [DUTY_BITS-1:0]   fwd_q [NUM_WHEELS];
  logic [DUTY_BITS-1:0]   rev_q [NUM_WHEELS];
  logic [DUTY_PORT_W-1:0] out_fwd_q [NUM_WHEELS];
  logic [DUTY_PORT_W-1:0] out_rev_q [NUM_WHEELS];
  logic [PULSE_W-1:0]     out_pulse_q;

  always_comb begin
    xd_d = $signed({1'b0, store_q[0]}) - $signed({1'b0, center_q});
    yd_d = $signed({1'b0, store_q[1]}) - $signed({1'b0, center_q});
    rd_d = $signed({1'b0, store_q[2]}) - $signed({1'b0, center_q});

    gain_ext = $signed({{(TURN_W - GAIN_W){1'b0}}, gain_q});
    rd_ext   = TURN_W'(rd_q);
    t_d      = gain_ext * rd_ext;
    yd_ext   = YK_W'(yd_q);
    sqrt_ext = YK_W'(SQRT3_HALF_Q16);
    yk_d     = yd_ext * sqrt_ext;

    x_ext  = ACC_W'(xd_q);
    yk_ext = ACC_W'(yk_q);
    t_ext  = ACC_W'(t_q);
    case (cmd_i.sel)
      SEL_W'(0): acc = (x_ext <<< X_SHIFT) + (t_ext <<< T_SHIFT);
      SEL_W'(1): acc = yk_ext - (x_ext <<< XH_SHIFT) + (t_ext <<< T_SHIFT);
      default:   acc = (t_ext <<< T_SHIFT) - (x_ext <<< XH_SHIFT) - yk_ext;
    endcase
    acc_abs = acc[ACC_W-1] ? ACC_W'(-acc) : ACC_W'(acc);

    rnd_sum   = (ROUND_W'(mag_q) << DUTY_BITS) + ROUND_W'(RND_OFS);
    rnd_shift = rnd_sum >> 16;
    scap_d    = (rnd_shift > ROUND_W'(SCAP)) ? SCAP_W'(SCAP) : rnd_shift[SCAP_W-1:0];

    prod = PROD_W'(scap_q) * PROD_W'(RECIP);

    lim  = (limit_q > DUTY_TOP) ? DUTY_TOP[DUTY_BITS-1:0] : limit_q[DUTY_BITS-1:0];
    duty = (quo_q > lim) ? lim : quo_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_q    <= CENTER_RST;
      gain_q      <= GAIN_RST;
      limit_q     <= LIMIT_RST;
      arm_code_q  <= ARM_CODE_RST;
      arm_on_q    <= ARM_ON_RST;
      arm_off_q   <= ARM_OFF_RST;
      prev_code_q <= '0;
      arm_pulse_q <= PULSE_RST;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_CENTER:  center_q   <= cfg_data_i[BYTE_W-1:0];
          CFG_GAIN:    gain_q     <= cfg_data_i[GAIN_W-1:0];
          CFG_LIMIT:   limit_q    <= cfg_data_i[LIMIT_W-1:0];
          CFG_ARMCODE: arm_code_q <= cfg_data_i[BYTE_W-1:0];
          CFG_ARM_ON:  arm_on_q   <= cfg_data_i[PULSE_W-1:0];
          CFG_ARM_OFF: arm_off_q  <= cfg_data_i[PULSE_W-1:0];
          default: ;
        endcase
      end
      if (cmd_i.op == OP_FRAME) begin
        prev_code_q <= rx_byte_i;
        if (rx_byte_i != prev_code_q) begin
          arm_pulse_q <= (rx_byte_i == arm_code_q) ? arm_on_q : arm_off_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_STORE: store_q[cmd_i.sel] <= rx_byte_i;
      OP_FRAME: begin
        xd_q <= xd_d;
        yd_q <= yd_d;
        rd_q <= rd_d;
      end
      OP_MUL: begin
        t_q  <= t_d;
        yk_q <= yk_d;
      end
      OP_ACC: begin
        mag_q     <= acc_abs[MAG_W-1:0];
        sgn_neg_q <= acc[ACC_W-1];
        sgn_pos_q <= !acc[ACC_W-1] && (acc != '0);
      end
      OP_ROUND: scap_q <= scap_d;
      OP_DIV:   quo_q  <= prod[RECIP_SHIFT +: DUTY_BITS];
      OP_CLAMP: begin
        fwd_q[cmd_i.sel] <= sgn_pos_q ? duty : '0;
        rev_q[cmd_i.sel] <= sgn_neg_q ? duty : '0;
      end
      OP_PUBLISH: begin
        for (int k = 0; k < NUM_WHEELS; k++) begin
          out_fwd_q[k] <= DUTY_PORT_W'(fwd_q[k]);
          out_rev_q[k] <= DUTY_PORT_W'(rev_q[k]);
        end
        out_pulse_q <= arm_pulse_q;
      end
      default: ;
    endcase
  end

  assign wheel1_fwd_o   = out_fwd_q[0];
  assign wheel1_rev_o   = out_rev_q[0];
  assign wheel2_fwd_o   = out_fwd_q[1];
  assign wheel2_rev_o   = out_rev_q[1];
  assign wheel3_fwd_o   = out_fwd_q[2];
  assign wheel3_rev_o   = out_rev_q[2];
  assign arm_pulse_us_o = out_pulse_q;

endmodule

FILE: rtl/core/omw_ctrl.sv
// ----------------------------------------------------------------------------
// omw_ctrl
// Controller of the omni drive mixer: tracks the byte position in the frame,
// sequences the shared wheel unit over the three wheels and owns the result
// handshake.
// ----------------------------------------------------------------------------
module omw_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output omw_pkg::omw_cmd_t cmd_o
);
  import omw_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ACC,
    ST_ROUND,
    ST_DIV,
    ST_CLAMP,
    ST_PUBLISH
  } state_e;

  state_e           state_q, state_d;
  logic [SEL_W-1:0] pos_q, pos_d;
  logic [SEL_W-1:0] wheel_q, wheel_d;
  logic             out_valid_q, out_valid_d;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    pos_d       = pos_q;
    wheel_d     = wheel_q;
    out_valid_d = out_valid_q && out_stall_i;
    cmd_o.op    = OP_NONE;
    cmd_o.sel   = wheel_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (pos_q != POS_LAST) begin
            cmd_o.op  = OP_STORE;
            cmd_o.sel = pos_q;
            pos_d     = pos_q + SEL_W'(1);
          end else begin
            cmd_o.op = OP_FRAME;
            pos_d    = '0;
            state_d  = ST_MUL;
          end
        end
      end
      ST_MUL: begin
        cmd_o.op = OP_MUL;
        wheel_d  = '0;
        state_d  = ST_ACC;
      end
      ST_ACC: begin
        cmd_o.op = OP_ACC;
        state_d  = ST_ROUND;
      end
      ST_ROUND: begin
        cmd_o.op = OP_ROUND;
        state_d  = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.op = OP_DIV;
        state_d  = ST_CLAMP;
      end
      ST_CLAMP: begin
        cmd_o.op = OP_CLAMP;
        if (wheel_q == WHEEL_LAST) begin
          state_d = ST_PUBLISH;
        end else begin
          wheel_d = wheel_q + SEL_W'(1);
          state_d = ST_ACC;
        end
      end
      ST_PUBLISH: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.op    = OP_PUBLISH;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pos_q       <= '0;
      wheel_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pos_q       <= pos_d;
      wheel_q     <= wheel_d;
      out_valid_q <= out_valid_d;
    end
  end

`ifndef SYNTH
  a_word_from_publish : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == ST_PUBLISH))
    else $error("result word raised outside the publish step");

  a_last_wheel_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLAMP && wheel_q == WHEEL_LAST) |=> (state_q == ST_PUBLISH))
    else $error("wheel sequence did not end after the last wheel");

  a_frame_start : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && pos_q == POS_LAST) |=> (state_q == ST_MUL && pos_q == '0))
    else $error("fourth byte did not start the wheel computation");
`endif

endmodule

FILE: rtl/core/omni_wheel_drive_mixer.sv
// ----------------------------------------------------------------------------
// omni_wheel_drive_mixer
// Gathers received bytes into four-byte frames (x, y, turn, arm code) and
// turns each frame into forward and reverse PWM duties for the three wheels
// of a kiwi base, plus the arm servo pulse width.
//
//   channel  direction  handshake              words
//   in       input      in_valid_i/in_stall_o  rx_byte_i
//   out      output     out_valid_o/out_stall_i wheel duties, arm_pulse_us_o
//   cfg      input      cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// The first three bytes of a frame are stored without a stall. The fourth byte
// keeps the input stalled through a product step, then the steps
// of the shared wheel unit (sum, round, reciprocal multiply, clamp)
// for each of the three wheels, then the load of the result register.
// The load waits, and the stall lasts longer, while an earlier result word
// still waits under out_stall_i; such a word does not block the next three
// bytes. Reset is asynchronous and active low; it restores the register
// defaults and starts a new frame.
// ----------------------------------------------------------------------------
module omni_wheel_drive_mixer (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [omw_pkg::BYTE_W-1:0]      rx_byte_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [omw_pkg::DUTY_PORT_W-1:0] wheel1_fwd_o,
  output logic [omw_pkg::DUTY_PORT_W-1:0] wheel1_rev_o,
  output logic [omw_pkg::DUTY_PORT_W-1:0] wheel2_fwd_o,
  output logic [omw_pkg::DUTY_PORT_W-1:0] wheel2_rev_o,
  output logic [omw_pkg::DUTY_PORT_W-1:0] wheel3_fwd_o,
  output logic [omw_pkg::DUTY_PORT_W-1:0] wheel3_rev_o,
  output logic [omw_pkg::PULSE_W-1:0]     arm_pulse_us_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [omw_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [omw_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import omw_pkg::*;

  omw_cmd_t cmd;

  assign cfg_ready_o = 1'b1;

  omw_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  omw_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .rx_byte_i      (rx_byte_i),
    .cfg_we_i       (cfg_valid_i && cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .wheel1_fwd_o   (wheel1_fwd_o),
    .wheel1_rev_o   (wheel1_rev_o),
    .wheel2_fwd_o   (wheel2_fwd_o),
    .wheel2_rev_o   (wheel2_rev_o),
    .wheel3_fwd_o   (wheel3_fwd_o),
    .wheel3_rev_o   (wheel3_rev_o),
    .arm_pulse_us_o (arm_pulse_us_o)
  );

endmodule

FILE: tb/tb_omni_wheel_drive_mixer.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_omni_wheel_drive_mixer
// Self-checking bench for the kiwi drive mixer. Bytes are pushed in with
// random gaps while the result side stalls at random. A scoreboard keeps its
// own copy of the frame assembly, registers and arm state, predicts the six
// wheel duties and the servo pulse of every frame, and compares each result
// word with the oldest prediction. Registers are reprogrammed between phases,
// including in the middle of a frame, over extreme and random settings.
// ----------------------------------------------------------------------------
module tb_omni_wheel_drive_mixer;
  import omw_pkg::*;

  localparam longint SIN60_Q16     = 56756;
  localparam longint COUNT_DEN     = longint'(127) * 65536;
  localparam int     SETTLE_CYCLES = 24;
  localparam int     NUM_PHASES    = 8;
  localparam longint RUN_LIMIT_NS  = 64'd40_000_000;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = CFG_IDX_W'(6);
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = CFG_IDX_W'(7);

  typedef struct {
    logic [DUTY_PORT_W-1:0] fwd [3];
    logic [DUTY_PORT_W-1:0] rev [3];
    logic [PULSE_W-1:0]     pulse;
  } duty_set_t;

  class wheel_duty_board;
    logic [BYTE_W-1:0]  center;
    logic [GAIN_W-1:0]  gain;
    logic [LIMIT_W-1:0] limit;
    logic [BYTE_W-1:0]  code_on;
    logic [PULSE_W-1:0] on_us;
    logic [PULSE_W-1:0] off_us;
    logic [1:0]         slot;
    logic [BYTE_W-1:0]  held [3];
    logic [BYTE_W-1:0]  last_code;
    logic [PULSE_W-1:0] pulse;
    duty_set_t          pending [$];
    int                 bytes_taken;
    int                 results_seen;
    int                 mismatches;

    function new();
      center       = 8'd127;
      gain         = 12'd640;
      limit        = 16'd64881;
      code_on      = 8'd35;
      on_us        = 12'd1190;
      off_us       = 12'd1700;
      slot         = 2'd0;
      last_code    = 8'd0;
      pulse        = 12'd1700;
      bytes_taken  = 0;
      results_seen = 0;
      mismatches   = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_CENTER:  center  = data[BYTE_W-1:0];
        CFG_GAIN:    gain    = data[GAIN_W-1:0];
        CFG_LIMIT:   limit   = data[LIMIT_W-1:0];
        CFG_ARMCODE: code_on = data[BYTE_W-1:0];
        CFG_ARM_ON:  on_us   = data[PULSE_W-1:0];
        CFG_ARM_OFF: off_us  = data[PULSE_W-1:0];
        default: ;
      endcase
    endfunction

    function void wheel_duty(longint acc, output logic [DUTY_PORT_W-1:0] fwd,
                             output logic [DUTY_PORT_W-1:0] rev);
      longint mag;
      longint duty;
      longint top;
      longint lim;
      mag  = (acc < 0) ? -acc : acc;
      top  = (longint'(1) << DUTY_BITS) - 1;
      lim  = (longint'(limit) < top) ? longint'(limit) : top;
      duty = (mag * (longint'(1) << DUTY_BITS) + COUNT_DEN / 2) / COUNT_DEN;
      if (duty > lim) duty = lim;
      fwd = (acc > 0) ? DUTY_PORT_W'(duty) : '0;
      rev = (acc < 0) ? DUTY_PORT_W'(duty) : '0;
    endfunction

    function void take_byte(logic [BYTE_W-1:0] b);
      longint x;
      longint y;
      longint r;
      longint t;
      longint acc [3];
      duty_set_t want;
      bytes_taken++;
      if (slot != 2'd3) begin
        held[slot] = b;
        slot++;
        return;
      end
      slot = 2'd0;
      x = longint'(held[0]) - longint'(center);
      y = longint'(held[1]) - longint'(center);
      r = longint'(held[2]) - longint'(center);
      t = longint'(gain) * r * 256;
      acc[0] = 65536 * x + t;
      acc[1] = -32768 * x + SIN60_Q16 * y + t;
      acc[2] = -32768 * x - SIN60_Q16 * y + t;
      if (b != last_code) begin
        pulse = (b == code_on) ? on_us : off_us;
      end
      last_code = b;
      for (int k = 0; k < 3; k++) begin
        wheel_duty(acc[k], want.fwd[k], want.rev[k]);
      end
      want.pulse = pulse;
      pending.push_back(want);
    endfunction

    function void note_mismatch(string what, longint want, longint got);
      mismatches++;
      if (mismatches <= 10) begin
        $display("Mismatch in result %0d, %s: expected %0d, got %0d",
                 results_seen, what, want, got);
      end
    endfunction

    function void check_result(duty_set_t got);
      duty_set_t want;
      if (pending.size() == 0) begin
        note_mismatch("word with no frame outstanding", 0, 0);
        return;
      end
      want = pending.pop_front();
      results_seen++;
      for (int k = 0; k < 3; k++) begin
        if (got.fwd[k] !== want.fwd[k]) begin
          note_mismatch($sformatf("wheel%0d_fwd", k + 1), want.fwd[k], got.fwd[k]);
        end
        if (got.rev[k] !== want.rev[k]) begin
          note_mismatch($sformatf("wheel%0d_rev", k + 1), want.rev[k], got.rev[k]);
        end
      end
      if (got.pulse !== want.pulse) begin
        note_mismatch("arm_pulse_us", want.pulse, got.pulse);
      end
    endfunction
  endclass

  logic                   clk_i;
  logic                   rst_ni;
  logic                   in_valid_i;
  logic                   in_stall_o;
  logic [BYTE_W-1:0]      rx_byte_i;
  logic                   out_valid_o;
  logic                   out_stall_i;
  logic [DUTY_PORT_W-1:0] wheel1_fwd_o;
  logic [DUTY_PORT_W-1:0] wheel1_rev_o;
  logic [DUTY_PORT_W-1:0] wheel2_fwd_o;
  logic [DUTY_PORT_W-1:0] wheel2_rev_o;
  logic [DUTY_PORT_W-1:0] wheel3_fwd_o;
  logic [DUTY_PORT_W-1:0] wheel3_rev_o;
  logic [PULSE_W-1:0]     arm_pulse_us_o;
  logic                   cfg_valid_i;
  logic                   cfg_ready_o;
  logic [CFG_IDX_W-1:0]   cfg_index_i;
  logic [CFG_DATA_W-1:0]  cfg_data_i;

  wheel_duty_board board;
  bit              steady_src;
  int              sink_left = 0;
  int              settings_used;

  omni_wheel_drive_mixer dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .rx_byte_i      (rx_byte_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .wheel1_fwd_o   (wheel1_fwd_o),
    .wheel1_rev_o   (wheel1_rev_o),
    .wheel2_fwd_o   (wheel2_fwd_o),
    .wheel2_rev_o   (wheel2_rev_o),
    .wheel3_fwd_o   (wheel3_fwd_o),
    .wheel3_rev_o   (wheel3_rev_o),
    .arm_pulse_us_o (arm_pulse_us_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("Timed out with %0d frames still outstanding.", board.pending.size());
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 85) return $urandom_range(1, 3);
    if (p < 97) return $urandom_range(4, 12);
    return $urandom_range(30, 80);
  endfunction

  function automatic int spread(int usual, int top);
    int p;
    p = $urandom_range(0, 99);
    if (p < 40) return usual;
    if (p < 55) return 0;
    if (p < 70) return top;
    return $urandom_range(0, top);
  endfunction

  function automatic logic [BYTE_W-1:0] pick_byte();
    int p;
    p = $urandom_range(0, 99);
    if (board.slot == 2'd3) begin
      if (p < 35) return board.code_on;
      if (p < 65) return board.last_code;
      if (p < 75) return 8'd0;
      return BYTE_W'($urandom);
    end
    if (p < 40) return BYTE_W'(board.center + $urandom_range(0, 20) - 10);
    if (p < 55) return 8'd0;
    if (p < 70) return 8'd255;
    return BYTE_W'($urandom);
  endfunction

  // The result side alternates stall bursts with free-running stretches.
  always @(posedge clk_i) begin
    if (sink_left > 0) begin
      sink_left--;
    end else if (out_stall_i) begin
      out_stall_i <= 1'b0;
      sink_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(0, 6);
    end else begin
      out_stall_i <= 1'b1;
      sink_left = pick_gap();
    end
  end

  always @(posedge clk_i) begin
    duty_set_t got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.fwd[0] = wheel1_fwd_o;
      got.rev[0] = wheel1_rev_o;
      got.fwd[1] = wheel2_fwd_o;
      got.rev[1] = wheel2_rev_o;
      got.fwd[2] = wheel3_fwd_o;
      got.rev[2] = wheel3_rev_o;
      got.pulse  = arm_pulse_us_o;
      board.check_result(got);
    end
  end

  task automatic push_byte(input logic [BYTE_W-1:0] b);
    int gap;
    gap = steady_src ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    board.take_byte(b);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    board.set_reg(idx, data);
  endtask

  // Random bits above the register width must be dropped by the block.
  task automatic set_field(input logic [CFG_IDX_W-1:0] idx, input int value, input int bits);
    logic [CFG_DATA_W-1:0] data;
    data = CFG_DATA_W'($urandom);
    for (int i = 0; i < bits; i++) data[i] = value[i];
    write_reg(idx, data);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic pick_settings(input bit all);
    if (all || $urandom_range(0, 5) != 0) set_field(CFG_CENTER, spread(127, 255), BYTE_W);
    if (all || $urandom_range(0, 5) != 0) set_field(CFG_GAIN, spread(640, 4095), GAIN_W);
    if (all || $urandom_range(0, 5) != 0) set_field(CFG_LIMIT, spread(64881, 65535), LIMIT_W);
    if (all || $urandom_range(0, 5) != 0) set_field(CFG_ARMCODE, spread(35, 255), BYTE_W);
    if (all || $urandom_range(0, 5) != 0) set_field(CFG_ARM_ON, spread(1190, 4095), PULSE_W);
    if (all || $urandom_range(0, 5) != 0) set_field(CFG_ARM_OFF, spread(1700, 4095), PULSE_W);
    if ($urandom_range(0, 4) == 0) begin
      write_reg($urandom_range(0, 1) ? CFG_SPARE_LO : CFG_SPARE_HI, CFG_DATA_W'($urandom));
    end
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    rx_byte_i     = '0;
    out_stall_i   = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    steady_src    = 1'b0;
    settings_used = 1;
    board         = new();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Centered first frame with code zero keeps the reset pulse.
    push_byte(8'd127); push_byte(8'd127); push_byte(8'd127); push_byte(8'd0);
    push_byte(8'd255); push_byte(8'd0);   push_byte(8'd255); push_byte(ARM_CODE_RST);
    push_byte(8'd0);   push_byte(8'd255); push_byte(8'd0);   push_byte(ARM_CODE_RST);

    // New arm pulse values must not apply while the code stays the same.
    settle();
    write_reg(CFG_ARM_ON, 16'hFFFF);
    write_reg(CFG_ARM_OFF, 16'd300);
    cfg_valid_i <= 1'b0;
    settings_used++;
    push_byte(8'd200); push_byte(8'd50);  push_byte(8'd127); push_byte(ARM_CODE_RST);
    push_byte(8'd128); push_byte(8'd126); push_byte(8'd130); push_byte(8'd99);

    // Registers change halfway through a frame; the zero limit forces all duties off.
    push_byte(8'd10); push_byte(8'd240);
    settle();
    write_reg(CFG_LIMIT, 16'd0);
    write_reg(CFG_CENTER, 16'd0);
    write_reg(CFG_GAIN, 16'hFFFF);
    write_reg(CFG_SPARE_LO, 16'hA5A5);
    write_reg(CFG_SPARE_HI, 16'h5A5A);
    write_reg(CFG_ARMCODE, 16'h00FF);
    cfg_valid_i <= 1'b0;
    settings_used++;
    push_byte(8'd255); push_byte(8'hFF);

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      settle();
      pick_settings(phase == 0);
      settings_used++;
      steady_src = ($urandom_range(0, 3) == 0);
      repeat (140 + $urandom_range(0, 3)) push_byte(pick_byte());
    end

    settle();
    $display("Sent %0d bytes and checked %0d frames under %0d register settings.",
             board.bytes_taken, board.results_seen, settings_used);
    $display("Field mismatches: %0d, frames never returned: %0d.",
             board.mismatches, board.pending.size());
    if (board.mismatches == 0 && board.pending.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
